// ===== src/adc_temperature_calibrator_macros.svh =====
// Assertion macros shared by the temperature calibrator modules.
`ifndef ADC_TEMPERATURE_CALIBRATOR_MACROS_SVH
`define ADC_TEMPERATURE_CALIBRATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/atc_pkg.sv =====
// Shared types, constants and lookup function of the temperature calibrator.
package atc_pkg;

    localparam int STATUS_W = 8;
    localparam int CHAN_W   = 3;
    localparam int RAW_W    = 24;
    localparam int MAG_W    = 20;
    localparam int TEMP_W   = 40;
    localparam int COEFF_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam int STATUS_BUSY_BIT = 7;

    // Pipeline stages
    localparam int STAGES   = 6;
    localparam int ST_DIST  = 0;
    localparam int ST_MAG   = 1;
    localparam int ST_TEMP  = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_TERM  = 4;
    localparam int ST_OUT   = 5;

    localparam logic [RAW_W-1:0] MIDSCALE = 24'h800000;

    // x / 10 for x < 2^26 as (x * RECIP10) >> 27
    localparam logic [23:0] RECIP10       = 24'hCCCCCD;
    localparam int          RECIP10_SHIFT = 27;
    localparam logic [MAG_W-1:0] MAG_BIAS = 20'd5;

    // x / 25 for x < 2^20 as (x * RECIP25) >> 25
    localparam logic [20:0] RECIP25       = 21'd1342178;
    localparam int          RECIP25_SHIFT = 25;
    localparam int          Q25_W         = 16;
    localparam logic [MAG_W-1:0] DIV25    = 20'd25;
    localparam int          FRAC_W        = 14;

    localparam int T_W   = 31;
    localparam int UX_W  = 30;
    localparam int SQ_W  = 2 * UX_W;
    localparam int LIN_W = COEFF_W + T_W;
    localparam int HI_W  = 20;
    localparam int LO_W  = 24;
    localparam int K2HI_W = COEFF_W + HI_W + 1;
    localparam int K2LO_W = COEFF_W + LO_W + 1;
    localparam int COEFF_FRAC = 24;
    localparam int BASE_W = 41;
    localparam int SUM_W  = 55;

    localparam logic signed [T_W-1:0] FIT_THRESH = 31'sd6553600;

    localparam logic signed [SUM_W-1:0]  SAT_MAX = 55'sd549755813887;
    localparam logic signed [SUM_W-1:0]  SAT_MIN = -55'sd549755813888;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 40'sh8000000000;

    localparam logic signed [COEFF_W-1:0] COEFF_LINEAR_RST = 32'sd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_ENABLE        = 3'd0,
        CFG_COEFF_SQUARE      = 3'd1,
        CFG_COEFF_LINEAR      = 3'd2,
        CFG_COEFF_OFFSET      = 3'd3,
        CFG_STREAM_CORRECTION = 3'd4,
        CFG_STREAM_CHANNEL    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                      fit_enable;
        logic signed [COEFF_W-1:0] coeff_square;
        logic signed [COEFF_W-1:0] coeff_linear;
        logic signed [COEFF_W-1:0] coeff_offset;
        logic signed [COEFF_W-1:0] stream_correction;
        logic [CHAN_W-1:0]         stream_channel;
    } cfg_t;

    typedef logic [STAGES-1:0] stage_vec_t;

    typedef struct packed {
        stage_vec_t en;
        stage_vec_t vld;
    } pipe_ctl_t;

    // floor((r * 16384 + 12) / 25): fractional part of (mag * 65536 + 50) / 100
    function automatic logic [FRAC_W-1:0] frac_lut(input logic [4:0] r);
        logic [FRAC_W-1:0] f;
        case (r)
            5'd0:    f = 14'd0;
            5'd1:    f = 14'd655;
            5'd2:    f = 14'd1311;
            5'd3:    f = 14'd1966;
            5'd4:    f = 14'd2621;
            5'd5:    f = 14'd3277;
            5'd6:    f = 14'd3932;
            5'd7:    f = 14'd4588;
            5'd8:    f = 14'd5243;
            5'd9:    f = 14'd5898;
            5'd10:   f = 14'd6554;
            5'd11:   f = 14'd7209;
            5'd12:   f = 14'd7864;
            5'd13:   f = 14'd8520;
            5'd14:   f = 14'd9175;
            5'd15:   f = 14'd9830;
            5'd16:   f = 14'd10486;
            5'd17:   f = 14'd11141;
            5'd18:   f = 14'd11796;
            5'd19:   f = 14'd12452;
            5'd20:   f = 14'd13107;
            5'd21:   f = 14'd13763;
            5'd22:   f = 14'd14418;
            5'd23:   f = 14'd15073;
            5'd24:   f = 14'd15729;
            default: f = 14'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== src/atc_sample_if.sv =====
// Sample channel: status, channel number and raw conversion code.
interface atc_sample_if;
    logic                         valid;
    logic                         ready;
    logic [atc_pkg::STATUS_W-1:0] status_byte;
    logic [atc_pkg::CHAN_W-1:0]   sensor_channel;
    logic [atc_pkg::RAW_W-1:0]    raw_code;

    modport source (output valid, output status_byte, output sensor_channel,
                    output raw_code, input ready);
    modport sink   (input valid, input status_byte, input sensor_channel,
                    input raw_code, output ready);
endinterface

// ===== src/atc_result_if.sv =====
// Result channel: echoed channel, magnitude, sign and calibrated temperature.
interface atc_result_if;
    logic                              valid;
    logic                              ready;
    logic [atc_pkg::CHAN_W-1:0]        channel_out;
    logic [atc_pkg::MAG_W-1:0]         magnitude;
    logic                              negative;
    logic signed [atc_pkg::TEMP_W-1:0] temperature_q16;

    modport source (output valid, output channel_out, output magnitude,
                    output negative, output temperature_q16, input ready);
    modport sink   (input valid, input channel_out, input magnitude,
                    input negative, input temperature_q16, output ready);
endinterface

// ===== src/atc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface atc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [atc_pkg::CFG_IDX_W-1:0] index;
    logic [atc_pkg::COEFF_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/atc_ctrl.sv =====
// Pipeline control: per-stage valid bits and advance enables.
`include "adc_temperature_calibrator_macros.svh"

module atc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_drop,
    input  logic               out_ready,
    output logic               in_ready,
    output atc_pkg::pipe_ctl_t ctl
);
    import atc_pkg::*;

    stage_vec_t vld_reg;
    stage_vec_t vld_next;
    stage_vec_t en;

    // a stage advances when it is empty or its successor advances
    always_comb
    begin
        en[ST_OUT] = !vld_reg[ST_OUT] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[ST_DIST])
        begin
            vld_next[ST_DIST] = in_valid && !in_drop;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = en[ST_DIST];
    assign ctl.en   = en;
    assign ctl.vld  = vld_reg;

    `ATC_ASSERT_NXT(a_out_hold, vld_reg[ST_OUT] && !out_ready, vld_reg[ST_OUT], "result word lost while stalled")
    `ATC_ASSERT_NXT(a_out_fill, vld_reg[ST_TERM] && en[ST_OUT], vld_reg[ST_OUT], "word lost entering output stage")
    `ATC_ASSERT_NXT(a_mid_hold, vld_reg[ST_TEMP] && !en[ST_SQ], vld_reg[ST_TEMP], "stalled stage dropped its word")

endmodule

// ===== src/atc_mag.sv =====
// Magnitude path: distance from mid-scale, /10 + 5, and Q16.16 scaling.
`include "adc_temperature_calibrator_macros.svh"

module atc_mag (
    input  logic                           clk,
    input  logic                           rst_n,
    input  atc_pkg::pipe_ctl_t             ctl,
    input  logic [atc_pkg::CHAN_W-1:0]     sensor_channel,
    input  logic [atc_pkg::RAW_W-1:0]      raw_code,
    output logic [atc_pkg::CHAN_W-1:0]     chan,
    output logic [atc_pkg::MAG_W-1:0]      mag,
    output logic                           neg,
    output logic signed [atc_pkg::T_W-1:0] temp
);
    import atc_pkg::*;

    // distance stage
    logic [RAW_W-1:0]   distance;
    logic               neg_in;
    logic [2*RAW_W-1:0] prod10_next;
    logic [2*RAW_W-1:0] prod10_reg;
    logic               neg_s0_reg;
    logic [CHAN_W-1:0]  chan_s0_reg;

    // magnitude stage
    logic [MAG_W-1:0]         mag_next;
    logic [MAG_W+20:0]        prod25_next;
    logic [MAG_W+20:0]        prod25_reg;
    logic [MAG_W-1:0]         mag_s1_reg;
    logic                     neg_s1_reg;
    logic [CHAN_W-1:0]        chan_s1_reg;

    // temperature stage
    logic [Q25_W-1:0]         q25;
    logic [MAG_W-1:0]         rem;
    logic [FRAC_W-1:0]        frac;
    logic [UX_W-1:0]          tmag;
    logic signed [T_W-1:0]    temp_next;
    logic signed [T_W-1:0]    temp_reg;
    logic [MAG_W-1:0]         mag_s2_reg;
    logic                     neg_s2_reg;
    logic [CHAN_W-1:0]        chan_s2_reg;

    always_comb
    begin
        neg_in      = raw_code < MIDSCALE;
        distance    = neg_in ? (MIDSCALE - raw_code) : (raw_code - MIDSCALE);
        prod10_next = distance * RECIP10;
    end

    always_comb
    begin
        mag_next    = prod10_reg[RECIP10_SHIFT +: MAG_W] + MAG_BIAS;
        prod25_next = mag_next * RECIP25;
    end

    // split mag = 25*q + r; scaled value is q*16384 + table(r)
    always_comb
    begin
        q25       = prod25_reg[RECIP25_SHIFT +: Q25_W];
        rem       = mag_s1_reg - MAG_W'(MAG_W'(q25) * DIV25);
        frac      = frac_lut(rem[4:0]);
        tmag      = {q25, {FRAC_W{1'b0}}} + UX_W'(frac);
        temp_next = neg_s1_reg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_DIST])
        begin
            prod10_reg  <= prod10_next;
            neg_s0_reg  <= neg_in;
            chan_s0_reg <= sensor_channel;
        end
        if (ctl.en[ST_MAG])
        begin
            prod25_reg  <= prod25_next;
            mag_s1_reg  <= mag_next;
            neg_s1_reg  <= neg_s0_reg;
            chan_s1_reg <= chan_s0_reg;
        end
        if (ctl.en[ST_TEMP])
        begin
            temp_reg    <= temp_next;
            mag_s2_reg  <= mag_s1_reg;
            neg_s2_reg  <= neg_s1_reg;
            chan_s2_reg <= chan_s1_reg;
        end
    end

    assign chan = chan_s2_reg;
    assign mag  = mag_s2_reg;
    assign neg  = neg_s2_reg;
    assign temp = temp_reg;

    `ATC_ASSERT_IMP(a_rem_range, ctl.vld[ST_MAG], rem < DIV25, "divide-by-25 remainder out of range")

endmodule

// ===== src/atc_fit.sv =====
// Calibration path: quadratic fit, stream correction and 40-bit saturation.
`include "adc_temperature_calibrator_macros.svh"

module atc_fit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  atc_pkg::pipe_ctl_t                ctl,
    input  atc_pkg::cfg_t                     cfg,
    input  logic [atc_pkg::CHAN_W-1:0]        chan,
    input  logic [atc_pkg::MAG_W-1:0]         mag,
    input  logic                              neg,
    input  logic signed [atc_pkg::T_W-1:0]    temp,
    output logic [atc_pkg::CHAN_W-1:0]        channel_out,
    output logic [atc_pkg::MAG_W-1:0]         magnitude,
    output logic                              negative,
    output logic signed [atc_pkg::TEMP_W-1:0] temperature_q16
);
    import atc_pkg::*;

    // square / linear product stage
    logic                     stream_in;
    logic                     fit_in;
    logic [SQ_W-1:0]          sq_next;
    logic signed [LIN_W-1:0]  lin_next;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [LIN_W-1:0]  lin_reg;
    logic signed [T_W-1:0]    temp_s3_reg;
    logic                     fit_s3_reg;
    logic                     stream_s3_reg;
    logic [MAG_W-1:0]         mag_s3_reg;
    logic                     neg_s3_reg;
    logic [CHAN_W-1:0]        chan_s3_reg;

    // term stage
    logic [HI_W-1:0]             hi;
    logic [LO_W-1:0]             lo;
    logic signed [K2HI_W-1:0]    k2hi_next;
    logic signed [K2LO_W-1:0]    k2lo_next;
    logic signed [COEFF_W-1:0]   corr;
    logic signed [BASE_W-1:0]    base_next;
    logic signed [K2HI_W-1:0]    k2hi_reg;
    logic signed [K2LO_W-1:0]    k2lo_reg;
    logic signed [BASE_W-1:0]    base_reg;
    logic                        fit_s4_reg;
    logic [MAG_W-1:0]            mag_s4_reg;
    logic                        neg_s4_reg;
    logic [CHAN_W-1:0]           chan_s4_reg;

    // output stage
    logic signed [SUM_W-1:0]     sqterm;
    logic signed [SUM_W-1:0]     total;
    logic signed [TEMP_W-1:0]    temp_next;
    logic signed [TEMP_W-1:0]    temp_out_reg;
    logic [MAG_W-1:0]            mag_out_reg;
    logic                        neg_out_reg;
    logic [CHAN_W-1:0]           chan_out_reg;

    always_comb
    begin
        stream_in = chan == cfg.stream_channel;
        fit_in    = cfg.fit_enable && stream_in && (temp > FIT_THRESH);
        sq_next   = temp[UX_W-1:0] * temp[UX_W-1:0];
        lin_next  = cfg.coeff_linear * temp;
    end

    // square term splits (x*x >> 16) into high and low parts about 2^24
    always_comb
    begin
        hi        = sq_reg[SQ_W-1 -: HI_W];
        lo        = sq_reg[16 +: LO_W];
        k2hi_next = cfg.coeff_square * $signed({1'b0, hi});
        k2lo_next = cfg.coeff_square * $signed({1'b0, lo});
        corr      = stream_s3_reg ? cfg.stream_correction : '0;
        if (fit_s3_reg)
        begin
            base_next = BASE_W'($signed(lin_reg[LIN_W-1:COEFF_FRAC]))
                      + BASE_W'(cfg.coeff_offset) + BASE_W'(corr);
        end
        else
        begin
            base_next = BASE_W'(temp_s3_reg) + BASE_W'(corr);
        end
    end

    always_comb
    begin
        sqterm = SUM_W'(k2hi_reg) + SUM_W'($signed(k2lo_reg[K2LO_W-1:COEFF_FRAC]));
        total  = SUM_W'(base_reg) + (fit_s4_reg ? sqterm : '0);
        if (total > SAT_MAX)
        begin
            temp_next = TEMP_MAX;
        end
        else if (total < SAT_MIN)
        begin
            temp_next = TEMP_MIN;
        end
        else
        begin
            temp_next = total[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SQ])
        begin
            sq_reg        <= sq_next;
            lin_reg       <= lin_next;
            temp_s3_reg   <= temp;
            fit_s3_reg    <= fit_in;
            stream_s3_reg <= stream_in;
            mag_s3_reg    <= mag;
            neg_s3_reg    <= neg;
            chan_s3_reg   <= chan;
        end
        if (ctl.en[ST_TERM])
        begin
            k2hi_reg    <= k2hi_next;
            k2lo_reg    <= k2lo_next;
            base_reg    <= base_next;
            fit_s4_reg  <= fit_s3_reg;
            mag_s4_reg  <= mag_s3_reg;
            neg_s4_reg  <= neg_s3_reg;
            chan_s4_reg <= chan_s3_reg;
        end
        if (ctl.en[ST_OUT])
        begin
            temp_out_reg <= temp_next;
            mag_out_reg  <= mag_s4_reg;
            neg_out_reg  <= neg_s4_reg;
            chan_out_reg <= chan_s4_reg;
        end
    end

    assign channel_out     = chan_out_reg;
    assign magnitude       = mag_out_reg;
    assign negative        = neg_out_reg;
    assign temperature_q16 = temp_out_reg;

    `ATC_ASSERT_IMP(a_fit_positive, ctl.vld[ST_SQ] && fit_s3_reg, !temp_s3_reg[T_W-1], "fit applied to a non-positive temperature")

endmodule

// ===== src/adc_temperature_calibrator.sv =====
// Top level of the converter-sample to calibrated-temperature pipeline.

// Takes one converter word per cycle unless a stalled result holds the pipe
// and offers one result word from the output stage: the echoed channel, the
// magnitude |raw - 0x800000| / 10 + 5, the sign flag and the temperature in
// signed Q16.16 degrees, saturated to 40 bits. A word whose status bit 7 is
// set is taken but gives no result. The six register stages are set by the
// two divisions by constants (each a reciprocal multiply) and by the square
// and coefficient multipliers of the calibration polynomial; each holds one
// word, and a stalled result holds every full stage behind it while empty
// ones still fill, so no space is lost. Write the configuration registers
// only while no word is in flight; the datapath reads them live.
module adc_temperature_calibrator (
    input  logic          clk,
    input  logic          rst_n,
    atc_sample_if.sink    sample,
    atc_result_if.source  result,
    atc_cfg_if.sink       cfg
);
    import atc_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    pipe_ctl_t ctl;
    logic      in_ready;

    logic [CHAN_W-1:0]     mag_chan;
    logic [MAG_W-1:0]      mag_val;
    logic                  mag_neg;
    logic signed [T_W-1:0] mag_temp;

    // Configuration: always ready; indexes past the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FIT_ENABLE:        cfg_next.fit_enable        = cfg.data[0];
                CFG_COEFF_SQUARE:      cfg_next.coeff_square      = $signed(cfg.data);
                CFG_COEFF_LINEAR:      cfg_next.coeff_linear      = $signed(cfg.data);
                CFG_COEFF_OFFSET:      cfg_next.coeff_offset      = $signed(cfg.data);
                CFG_STREAM_CORRECTION: cfg_next.stream_correction = $signed(cfg.data);
                CFG_STREAM_CHANNEL:    cfg_next.stream_channel    = cfg.data[CHAN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fit_enable        <= 1'b0;
            cfg_reg.coeff_square      <= '0;
            cfg_reg.coeff_linear      <= COEFF_LINEAR_RST;
            cfg_reg.coeff_offset      <= '0;
            cfg_reg.stream_correction <= '0;
            cfg_reg.stream_channel    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Valid bits and stage enables; drop not-ready converter words at entry.
    atc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_drop   (sample.status_byte[STATUS_BUSY_BIT]),
        .out_ready (result.ready),
        .in_ready  (in_ready),
        .ctl       (ctl)
    );

    assign sample.ready = in_ready;

    // Stages one to three: distance, magnitude and Q16.16 scaling.
    atc_mag u_mag (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sensor_channel (sample.sensor_channel),
        .raw_code       (sample.raw_code),
        .chan           (mag_chan),
        .mag            (mag_val),
        .neg            (mag_neg),
        .temp           (mag_temp)
    );

    // Stages four to six: polynomial fit, correction, saturation.
    atc_fit u_fit (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cfg             (cfg_reg),
        .chan            (mag_chan),
        .mag             (mag_val),
        .neg             (mag_neg),
        .temp            (mag_temp),
        .channel_out     (result.channel_out),
        .magnitude       (result.magnitude),
        .negative        (result.negative),
        .temperature_q16 (result.temperature_q16)
    );

    assign result.valid = ctl.vld[ST_OUT];

endmodule

// ===== verif/atc_reading_checker.sv =====
// Checker for the calibrator: predicts every result word and compares it.
`timescale 1ns / 100ps
module atc_reading_checker (
    input  logic  clk,
    input  logic  rst_n,
    atc_sample_if sample,
    atc_result_if result,
    atc_cfg_if    cfg,
    output int    pending_words,
    output int    mismatch_count
);
    import atc_pkg::*;

    localparam longint TEMP_CEIL  = 64'sd549755813887;
    localparam longint TEMP_FLOOR = -64'sd549755813888;
    localparam longint FIT_LIMIT  = 64'sd6553600;     // 100 degrees in Q16.16
    localparam logic signed [COEFF_W-1:0] LINEAR_ONE = 32'sh0100_0000;

    typedef struct packed {
        logic [CHAN_W-1:0]         chan;
        logic [MAG_W-1:0]          mag;
        logic                      neg;
        logic signed [TEMP_W-1:0]  temp;
    } reading_t;

    cfg_t     cal;
    reading_t expected_readings[$];
    reading_t want;
    reading_t got;

    function automatic reading_t predict_reading(input cfg_t c, input logic [CHAN_W-1:0] chan,
                                                 input logic [RAW_W-1:0] raw);
        reading_t r;
        longint   distance;
        longint   mag;
        longint   tmag;
        longint   t;
        longint   sq16;
        longint   k2;
        longint   k1;
        longint   hi;
        longint   lo;
        if (raw >= MIDSCALE)
        begin
            distance = longint'(raw) - longint'(MIDSCALE);
            r.neg    = 1'b0;
        end
        else
        begin
            distance = longint'(MIDSCALE) - longint'(raw);
            r.neg    = 1'b1;
        end
        mag  = distance / 10 + 5;
        tmag = (mag * 65536 + 50) / 100;
        t    = r.neg ? -tmag : tmag;
        if (chan == c.stream_channel)
        begin
            if (c.fit_enable && t > FIT_LIMIT)
            begin
                // split the square so the Q8.24 product stays inside 64 bits
                sq16 = (t * t) >>> 16;
                k2   = $signed(c.coeff_square);
                k1   = $signed(c.coeff_linear);
                hi   = sq16 >>> 24;
                lo   = sq16 & 64'h0000_0000_00FF_FFFF;
                t    = k2 * hi + ((k2 * lo) >>> 24) + ((k1 * t) >>> 24)
                       + longint'($signed(c.coeff_offset));
            end
            t = t + longint'($signed(c.stream_correction));
        end
        if (t > TEMP_CEIL)
            t = TEMP_CEIL;
        if (t < TEMP_FLOOR)
            t = TEMP_FLOOR;
        r.chan = chan;
        r.mag  = mag[MAG_W-1:0];
        r.temp = t[TEMP_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal              = '0;
            cal.coeff_linear = LINEAR_ONE;
            expected_readings.delete();
            pending_words  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_FIT_ENABLE:        cal.fit_enable        = cfg.data[0];
                    CFG_COEFF_SQUARE:      cal.coeff_square      = cfg.data;
                    CFG_COEFF_LINEAR:      cal.coeff_linear      = cfg.data;
                    CFG_COEFF_OFFSET:      cal.coeff_offset      = cfg.data;
                    CFG_STREAM_CORRECTION: cal.stream_correction = cfg.data;
                    CFG_STREAM_CHANNEL:    cal.stream_channel    = cfg.data[CHAN_W-1:0];
                    default: ;
                endcase
            end

            // a word flagged not ready yields nothing
            if (sample.valid && sample.ready && !sample.status_byte[STATUS_BUSY_BIT])
                expected_readings.push_back(predict_reading(cal, sample.sensor_channel,
                                                            sample.raw_code));

            if (result.valid && result.ready)
            begin
                got.chan = result.channel_out;
                got.mag  = result.magnitude;
                got.neg  = result.negative;
                got.temp = result.temperature_q16;
                if (expected_readings.size() == 0)
                begin
                    $error("unexpected result word: channel_out %0d temperature_q16 %0d",
                           got.chan, $signed(got.temp));
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got !== want)
                        mismatch_count <= mismatch_count + 1;
                    if (got.chan !== want.chan)
                        $error("channel_out: expected %0d, got %0d", want.chan, got.chan);
                    if (got.mag !== want.mag)
                        $error("magnitude: expected %0d, got %0d", want.mag, got.mag);
                    if (got.neg !== want.neg)
                        $error("negative: expected %0d, got %0d", want.neg, got.neg);
                    if (got.temp !== want.temp)
                        $error("temperature_q16: expected %0d, got %0d",
                               $signed(want.temp), $signed(got.temp));
                end
            end
            pending_words <= expected_readings.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the temperature calibrator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_top;
    import atc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 3 * STAGES;
    localparam int LONG_HOLD       = 200;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 125;
    // first distance from mid-scale whose temperature lies above 100 degrees
    localparam int THRESH_DIST     = 99960;

    logic clk = 1'b0;
    logic rst_n;
    logic want_long_hold = 1'b0;
    int   mismatch_count;
    int   pending_words;
    int   idle_cycles = 0;
    int   burst_left = 0;
    cfg_t setting;

    atc_sample_if sample_bus();
    atc_result_if result_bus();
    atc_cfg_if    cfg_bus();

    adc_temperature_calibrator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    atc_reading_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample_bus),
        .result         (result_bus),
        .cfg            (cfg_bus),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    always #5 clk = ~clk;

    // Offer one sample word and hold it until the block takes it. Words go out
    // in bursts of random length; between bursts drop valid for a random gap,
    // or for none at all so that some bursts run straight into the next.
    task automatic send_word(input logic [STATUS_W-1:0] st, input logic [CHAN_W-1:0] ch,
                             input logic [RAW_W-1:0] raw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.status_byte    <= st;
        sample_bus.sensor_channel <= ch;
        sample_bus.raw_code       <= raw;
        do @(posedge clk); while (!sample_bus.ready);
        burst_left--;
    endtask

    // Stop offering, wait for every predicted result word to come back, then
    // let the pipe run on so that words flagged not ready, which give no result,
    // have left it as well.
    task automatic settle();
        sample_bus.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all six registers back to back; valid stays high between writes
    // and drops only after the last one is taken.
    task automatic program_regs(input cfg_t c);
        cfg_idx_t           idx;
        logic [COEFF_W-1:0] value;
        idx = idx.first();
        repeat (idx.num())
        begin
            value = '0;
            case (idx)
                CFG_FIT_ENABLE:        value[0]          = c.fit_enable;
                CFG_COEFF_SQUARE:      value             = c.coeff_square;
                CFG_COEFF_LINEAR:      value             = c.coeff_linear;
                CFG_COEFF_OFFSET:      value             = c.coeff_offset;
                CFG_STREAM_CORRECTION: value             = c.stream_correction;
                CFG_STREAM_CHANNEL:    value[CHAN_W-1:0] = c.stream_channel;
                default: ;
            endcase
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= value;
            do @(posedge clk); while (!cfg_bus.ready);
            idx = idx.next();
        end
        cfg_bus.valid <= 1'b0;
        setting = c;
    endtask

    // Coefficients: the two extremes, zero, anything at all, or a value
    // within one unit of zero in Q8.24 (a plausible calibration).
    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return $urandom();
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // Random sample: status bit 7 set about one word in eight, half the words
    // on the stream channel, and codes spread over the full range, both sides
    // of mid-scale and the 100-degree threshold of the fit.
    task automatic send_random_word();
        logic [STATUS_W-1:0] st;
        logic [CHAN_W-1:0]   ch;
        logic [RAW_W-1:0]    raw;
        st = STATUS_W'($urandom());
        st[STATUS_BUSY_BIT] = ($urandom_range(0, 7) == 0);
        ch = ($urandom_range(0, 1) == 1) ? setting.stream_channel : CHAN_W'($urandom());
        case ($urandom_range(0, 3))
            0:       raw = RAW_W'($urandom());
            1:       raw = MIDSCALE + RAW_W'($urandom_range(0, 200000));
            2:       raw = MIDSCALE - RAW_W'($urandom_range(0, 200000));
            default: raw = MIDSCALE + RAW_W'(THRESH_DIST - 16 + $urandom_range(0, 32));
        endcase
        send_word(st, ch, raw);
    endtask

    // Receiver: ready follows a pattern of its own in segments of random
    // length - always ready, coin toss, two in three, or mostly stalled. On
    // request, hold ready low for a long stretch so the pipe fills and the
    // block stops taking sample words.
    initial
    begin : receiver
        int mode;
        int seg_left;
        result_bus.ready <= 1'b0;
        mode     = 0;
        seg_left = 0;
        forever
        begin
            @(posedge clk);
            if (want_long_hold)
            begin
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                want_long_hold = 1'b0;
                seg_left = 0;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= ($urandom_range(0, 1) == 1);
                2:       result_bus.ready <= (seg_left % 3 != 0);
                default: result_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t c;
        rst_n                     <= 1'b0;
        sample_bus.valid          <= 1'b0;
        sample_bus.status_byte    <= '0;
        sample_bus.sensor_channel <= '0;
        sample_bus.raw_code       <= '0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= CFG_FIT_ENABLE;
        cfg_bus.data              <= '0;
        setting              = '0;
        setting.coeff_linear = 32'sh0100_0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fit off, stream channel 0, no correction.
        send_word(8'h00, 3'd0, MIDSCALE);
        send_word(8'h00, 3'd0, 24'h000000);
        send_word(8'h7F, 3'd0, 24'hFFFF_FF);

        // Modest polynomial on channel 3: mid-scale, both ends of the code
        // range, exactly 100 degrees and the first code above it, the
        // smallest distances, a large negative reading, not-ready words.
        settle();
        c = '{fit_enable: 1'b1, coeff_square: 32'sh0010_0000, coeff_linear: 32'sh0100_0000,
              coeff_offset: 32'sh0001_0000, stream_correction: -32'sh0000_8000,
              stream_channel: 3'd3};
        program_regs(c);
        send_word(8'h00, 3'd3, MIDSCALE);
        send_word(8'h00, 3'd3, 24'h000000);
        send_word(8'h7F, 3'd3, 24'hFFFF_FF);
        send_word(8'h00, 3'd3, MIDSCALE + RAW_W'(THRESH_DIST - 1));
        send_word(8'h00, 3'd3, MIDSCALE + RAW_W'(THRESH_DIST));
        send_word(8'h80, 3'd3, 24'h12_3456);
        send_word(8'hFF, 3'd0, 24'hFFFF_FF);
        send_word(8'h01, 3'd0, 24'hFFFF_FF);
        send_word(8'h40, 3'd7, 24'h000000);
        send_word(8'h00, 3'd3, 24'h7F_FFFF);
        send_word(8'h00, 3'd3, 24'h80_0009);
        send_word(8'h00, 3'd3, 24'h80_000A);
        send_word(8'h55, 3'd3, MIDSCALE - RAW_W'(THRESH_DIST));
        send_word(8'hAA, 3'd5, 24'h55_5555);

        // Largest coefficients on channel 7: drive the sum into the upper clamp.
        settle();
        c = '{fit_enable: 1'b1, coeff_square: 32'sh7FFF_FFFF, coeff_linear: 32'sh7FFF_FFFF,
              coeff_offset: 32'sh7FFF_FFFF, stream_correction: 32'sh7FFF_FFFF,
              stream_channel: 3'd7};
        program_regs(c);
        send_word(8'h00, 3'd7, 24'hFFFF_FF);
        send_word(8'h00, 3'd7, MIDSCALE + RAW_W'(THRESH_DIST));
        send_word(8'h00, 3'd0, 24'hFFFF_FF);

        // Most negative coefficients on channel 0: the lower clamp.
        settle();
        c = '{fit_enable: 1'b1, coeff_square: 32'sh8000_0000, coeff_linear: 32'sh8000_0000,
              coeff_offset: 32'sh8000_0000, stream_correction: 32'sh8000_0000,
              stream_channel: 3'd0};
        program_regs(c);
        send_word(8'h00, 3'd0, 24'hFFFF_FF);
        send_word(8'h00, 3'd0, 24'h000000);
        send_word(8'h00, 3'd0, MIDSCALE + RAW_W'(THRESH_DIST));

        // Fit disabled: correction alone on the stream channel.
        settle();
        c.fit_enable     = 1'b0;
        c.stream_channel = 3'd2;
        program_regs(c);
        send_word(8'h00, 3'd2, 24'hFFFF_FF);

        // Random phases, each under fresh settings written while idle.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            c.fit_enable        = (p % 3 != 2);
            c.coeff_square      = pick_coeff();
            c.coeff_linear      = pick_coeff();
            c.coeff_offset      = pick_coeff();
            c.stream_correction = pick_coeff();
            c.stream_channel    = CHAN_W'($urandom_range(0, 7));
            program_regs(c);
            // one phase runs against a long receiver hold-off
            if (p == 1)
                want_long_hold = 1'b1;
            repeat (WORDS_PER_PHASE) send_random_word();
        end

        settle();
        if (mismatch_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== adc_temperature_calibrator.f =====
+incdir+src
src/atc_pkg.sv
src/atc_sample_if.sv
src/atc_result_if.sv
src/atc_cfg_if.sv
src/atc_ctrl.sv
src/atc_mag.sv
src/atc_fit.sv
src/adc_temperature_calibrator.sv
verif/atc_reading_checker.sv
verif/tb_top.sv
